### rtl/cuir_pkg.sv
// ----------------------------------------------------------------------------
// cuir_pkg: shared types and constants
// Payload structs, status codes and datapath widths of the cubic root block.
// ----------------------------------------------------------------------------
`default_nettype none

package cuir_pkg;

  // default configuration
  localparam int MAX_TRIES_DEF   = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  // datapath widths
  localparam int XW  = 38;   // signed Horner and offer values
  localparam int MW  = 33;   // second multiplier operand
  localparam int DW  = 37;   // unsigned divider operands
  localparam int SQW = 64;   // square root radicand
  localparam int RW  = 32;   // square root result
  localparam int EPSW = 16;

  localparam logic [EPSW-1:0] EPS_RESET = 16'd1;

  // status codes
  localparam logic [1:0] ST_CLOSED    = 2'd0;
  localparam logic [1:0] ST_CONVERGED = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_ZERO_DER  = 2'd3;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
  } in_t;

  typedef struct packed {
    logic [16:0] root_t;
    logic [1:0]  status;
  } out_t;

endpackage

`default_nettype wire

### rtl/cuir_div.sv
// ----------------------------------------------------------------------------
// cuir_div: serial fraction divider
// floor(num * 2^T / den) for num < 2*den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cuir_div #(
  parameter int T_FRAC_BITS = cuir_pkg::T_FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [cuir_pkg::DW-1:0] num,
  input  wire logic [cuir_pkg::DW-1:0] den,
  output logic                         done,
  output logic [T_FRAC_BITS+1:0]       quo
);

  localparam int QW   = T_FRAC_BITS + 2;
  localparam int DW   = cuir_pkg::DW;
  localparam int CNTW = $clog2(T_FRAC_BITS + 1);

  logic [DW:0]     rem_r;
  logic [DW-1:0]   den_r;
  logic [QW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [DW:0] num_x;
  logic [DW:0] den_x;
  logic [DW:0] sh;
  logic        ge0;
  logic        ge1;

  assign num_x = {1'b0, num};
  assign den_x = {1'b0, den_r};
  assign ge0   = num >= den;
  assign sh    = rem_r << 1;
  assign ge1   = sh >= den_x;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == CNTW'(1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  // restoring shift-subtract step
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= ge0 ? num_x - {1'b0, den} : num_x;
      den_r <= den;
      q_r   <= QW'(ge0);
      cnt_r <= CNTW'(T_FRAC_BITS);
    end else if (busy_r) begin
      rem_r <= ge1 ? sh - den_x : sh;
      q_r   <= {q_r[QW-2:0], ge1};
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  assign done = done_r;
  assign quo  = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");

endmodule

`default_nettype wire

### rtl/cuir_sqrt.sv
// ----------------------------------------------------------------------------
// cuir_sqrt: serial integer square root
// floor(sqrt(m)) for a 64-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cuir_sqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [cuir_pkg::SQW-1:0] m,
  output logic                          done,
  output logic [cuir_pkg::RW-1:0]       root
);

  localparam int SQW = cuir_pkg::SQW;

  logic [SQW-1:0] m_r;
  logic [SQW-1:0] res_r;
  logic [SQW-1:0] bit_r;
  logic           busy_r;
  logic           done_r;
  logic [SQW-1:0] sum;

  assign sum = res_r + bit_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  // digit-by-digit step
  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= m;
      res_r <= '0;
      bit_r <= SQW'(1) << (SQW - 2);
    end else if (busy_r) begin
      if (m_r >= sum) begin
        m_r   <= m_r - sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[cuir_pkg::RW-1:0];

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("sqrt restarted while busy");
  a_bit_alive: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot(bit_r)) else $error("sqrt bit lost");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("sqrt done while busy");

endmodule

`default_nettype wire

### rtl/cubic_unit_interval_root_top.sv
// ----------------------------------------------------------------------------
// cubic_unit_interval_root_top: root of a cubic in [0,1]
// Closed form for quadratic and linear cases and for roots at 0 or 1, clamped Newton steps otherwise.
// ----------------------------------------------------------------------------
//  port group | direction | handshake          | payload
//  in_*       | input     | in_valid / in_stall   | cuir_pkg::in_t
//  out_*      | output    | out_valid / out_stall | cuir_pkg::out_t
//  cfg_*      | input     | cfg_valid / cfg_ready | epsilon, 16 bits
//
//  One item at a time; in_stall is high from acceptance until the result is
//  loaded into the output register. A Newton step makes five passes of the
//  shared multiplier plus the serial divider, repeated up to MAX_TRIES times
//  per item. The quadratic path uses the square root plus up to two divides.
//  Reset (rst_n low, synchronous) sets epsilon to 1 and empties the block.
//  A stalled result holds; the next item may be accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_unit_interval_root_top #(
  parameter int MAX_TRIES   = cuir_pkg::MAX_TRIES_DEF,
  parameter int T_FRAC_BITS = cuir_pkg::T_FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire cuir_pkg::in_t             in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output cuir_pkg::out_t                 out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [cuir_pkg::EPSW-1:0] cfg_data
);

  localparam int XW   = cuir_pkg::XW;
  localparam int MW   = cuir_pkg::MW;
  localparam int DW   = cuir_pkg::DW;
  localparam int PW   = XW + MW;
  localparam int TW   = T_FRAC_BITS + 1;
  localparam int QW   = T_FRAC_BITS + 2;
  localparam int NTW  = TW + 3;
  localparam int CW   = (NTW > cuir_pkg::EPSW) ? NTW : cuir_pkg::EPSW;
  localparam int KW   = 66;
  localparam int TRW  = $clog2(MAX_TRIES + 1);

  localparam logic [TW-1:0] T_ONE  = TW'(1) << T_FRAC_BITS;
  localparam logic [TW-1:0] T_HALF = TW'(1) << (T_FRAC_BITS - 1);
  localparam logic [QW-1:0] T_TWO  = QW'(1) << (T_FRAC_BITS + 1);

  // Horner step numbers
  localparam logic [2:0] STEP_FB = 3'd0;
  localparam logic [2:0] STEP_FC = 3'd1;
  localparam logic [2:0] STEP_FD = 3'd2;
  localparam logic [2:0] STEP_DB = 3'd3;
  localparam logic [2:0] STEP_DC = 3'd4;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_CLASS = 17'h00002,
    S_NMUL  = 17'h00004,
    S_NADD  = 17'h00008,
    S_NCHK  = 17'h00010,
    S_NDIV  = 17'h00020,
    S_NUPD  = 17'h00040,
    S_QSQ   = 17'h00080,
    S_QBD   = 17'h00100,
    S_QM    = 17'h00200,
    S_QCHK  = 17'h00400,
    S_QSQRT = 17'h00800,
    S_QRR   = 17'h01000,
    S_QS    = 17'h02000,
    S_OFFER = 17'h04000,
    S_ODIV  = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] a_r, b_r, c_r, d_r;
  logic [cuir_pkg::EPSW-1:0] eps_r;
  logic signed [XW-1:0] acc_r, fv_r;
  logic signed [PW-1:0] prod_r;
  logic signed [KW-1:0] m_r;
  logic [cuir_pkg::RW-1:0] r0_r;
  logic signed [XW-1:0] n_r, num_r, den_r;
  logic                 oidx_r, found_r;
  logic [TW-1:0]        best_r, t_r;
  logic [QW-1:0]        dmag_r;
  logic [1:0]           st_r;
  logic [2:0]           step_r;
  logic [TRW-1:0]       tries_r;
  logic                 out_valid_r;
  cuir_pkg::out_t       out_data_r;

  // shared multiplier operands
  logic signed [XW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic [31:0]          uc;

  assign uc = c_r[31] ? 32'(-c_r) : 32'(c_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_NMUL: begin
        mul_a = acc_r;
        mul_b = signed'(MW'(t_r));
      end
      S_QSQ: begin
        mul_a = signed'(XW'(uc));
        mul_b = signed'(MW'(uc));
      end
      S_QBD: begin
        mul_a = XW'(b_r);
        mul_b = MW'(d_r);
      end
      S_QRR: begin
        mul_a = signed'(XW'(r0_r));
        mul_b = signed'(MW'(r0_r));
      end
      default: ;
    endcase
  end

  // Horner accumulate
  logic signed [XW-1:0] shifted, addend, hsum, a3, b2;
  assign shifted = XW'(prod_r >>> T_FRAC_BITS);
  assign a3 = (XW'(a_r) <<< 1) + XW'(a_r);
  assign b2 = XW'(b_r) <<< 1;

  always_comb begin
    unique case (step_r)
      STEP_FB: addend = XW'(b_r);
      STEP_FC: addend = XW'(c_r);
      STEP_FD: addend = XW'(d_r);
      STEP_DB: addend = b2;
      default: addend = XW'(c_r);
    endcase
  end
  assign hsum = shifted + addend;

  // Newton magnitudes and update
  logic [DW-1:0] nu, de;
  logic [XW-1:0] de2;
  assign nu  = fv_r[XW-1]  ? DW'(-fv_r)  : DW'(fv_r);
  assign de  = acc_r[XW-1] ? DW'(-acc_r) : DW'(acc_r);
  assign de2 = {de, 1'b0};

  logic signed [NTW-1:0] nt, ts, dm;
  logic [TW-1:0] ntc, diff;
  assign ts = signed'(NTW'(t_r));
  assign dm = signed'(NTW'(dmag_r));
  assign nt = (fv_r[XW-1] != acc_r[XW-1]) ? ts + dm : ts - dm;

  always_comb begin
    if (nt < 0) ntc = '0;
    else if (nt > signed'(NTW'(T_ONE))) ntc = T_ONE;
    else ntc = TW'(nt);
  end
  assign diff = (ntc > t_r) ? ntc - t_r : t_r - ntc;

  // quadratic root selection
  logic [33:0] s_val;
  logic [KW-1:0] rr_sum;
  logic signed [XW-1:0] n_val;
  assign rr_sum = KW'(prod_r) + KW'(r0_r) + KW'(~c_r[0]);
  assign s_val  = {1'b0, r0_r, 1'b0} + 34'(rr_sum <= KW'(m_r));
  assign n_val  = c_r[31] ? signed'(XW'(s_val)) - XW'(c_r)
                          : -(XW'(c_r) + signed'(XW'(s_val)));

  // offer normalization
  logic signed [XW-1:0] o_num, o_den;
  logic                 o_ok;
  assign o_num = den_r[XW-1] ? -num_r : num_r;
  assign o_den = den_r[XW-1] ? -den_r : den_r;
  assign o_ok  = (den_r != '0) && !o_num[XW-1] && (o_num <= o_den);

  // shared divider
  logic          div_start, div_done;
  logic [DW-1:0] div_num, div_den;
  logic [QW-1:0] div_q;

  assign div_start = (state_r == S_NCHK && acc_r != '0 && !(XW'(nu) >= de2))
                  || (state_r == S_OFFER && o_ok);
  assign div_num   = (state_r == S_OFFER) ? DW'(o_num) : nu;
  assign div_den   = (state_r == S_OFFER) ? DW'(o_den) : de;

  cuir_div #(.T_FRAC_BITS(T_FRAC_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  logic sq_start, sq_done;
  logic [cuir_pkg::RW-1:0] sq_root;
  assign sq_start = (state_r == S_QCHK) && !m_r[KW-1];

  cuir_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .m    (cuir_pkg::SQW'(m_r)),
    .done (sq_done),
    .root (sq_root)
  );

  // candidate after a finished divide
  logic          upd_found;
  logic [TW-1:0] upd_best;
  always_comb begin
    upd_found = found_r;
    upd_best  = best_r;
    if (state_r == S_ODIV &&
        (!found_r || div_q < QW'(best_r))) begin
      upd_found = 1'b1;
      upd_best  = TW'(div_q);
    end else if (state_r == S_ODIV) begin
      upd_found = 1'b1;
    end
  end

  logic signed [33:0] coef_sum;
  assign coef_sum = 34'(a_r) + 34'(b_r) + 34'(c_r) + 34'(d_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CLASS;
      S_CLASS: begin
        if (a_r == '0) begin
          if (d_r == '0) state_nxt = S_DONE;
          else if (b_r == '0) state_nxt = S_OFFER;
          else state_nxt = S_QSQ;
        end else if (d_r == '0 || coef_sum == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NMUL;
        end
      end
      S_NMUL:  state_nxt = S_NADD;
      S_NADD:  state_nxt = (step_r == STEP_DC) ? S_NCHK : S_NMUL;
      S_NCHK: begin
        if (acc_r == '0) state_nxt = S_DONE;
        else if (div_start) state_nxt = S_NDIV;
        else state_nxt = S_NUPD;
      end
      S_NDIV:  if (div_done) state_nxt = S_NUPD;
      S_NUPD: begin
        if (CW'(diff) <= CW'(eps_r) || tries_r == TRW'(MAX_TRIES - 1))
          state_nxt = S_DONE;
        else
          state_nxt = S_NMUL;
      end
      S_QSQ:   state_nxt = S_QBD;
      S_QBD:   state_nxt = S_QM;
      S_QM:    state_nxt = S_QCHK;
      S_QCHK:  state_nxt = m_r[KW-1] ? S_DONE : S_QSQRT;
      S_QSQRT: if (sq_done) state_nxt = S_QRR;
      S_QRR:   state_nxt = S_QS;
      S_QS:    state_nxt = S_OFFER;
      S_OFFER: begin
        if (o_ok) state_nxt = S_ODIV;
        else if (oidx_r) state_nxt = S_DONE;
      end
      S_ODIV:  if (div_done && oidx_r) state_nxt = S_DONE;
               else if (div_done) state_nxt = S_OFFER;
      S_DONE:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) eps_r <= cuir_pkg::EPS_RESET;
    else if (cfg_valid && cfg_ready) eps_r <= cfg_data;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        a_r <= in_data.coef_a;
        b_r <= in_data.coef_b;
        c_r <= in_data.coef_c;
        d_r <= in_data.coef_d;
      end
      S_CLASS: begin
        found_r <= 1'b0;
        best_r  <= '0;
        num_r   <= -XW'(d_r);
        den_r   <= XW'(c_r);
        oidx_r  <= 1'b1;
        step_r  <= STEP_FB;
        tries_r <= '0;
        acc_r   <= XW'(a_r);
        // Newton start at one half, sum of zero means root at one
        if (a_r != '0 && d_r != '0 && coef_sum != '0) begin
          t_r  <= T_HALF;
          st_r <= cuir_pkg::ST_EXHAUSTED;
        end else if (a_r != '0 && d_r != '0) begin
          t_r  <= T_ONE;
          st_r <= cuir_pkg::ST_CLOSED;
        end else begin
          t_r  <= '0;
          st_r <= cuir_pkg::ST_CLOSED;
        end
      end
      S_NMUL: prod_r <= mul_a * mul_b;
      S_NADD: begin
        step_r <= step_r + 3'd1;
        if (step_r == STEP_FD) begin
          fv_r  <= hsum;
          acc_r <= a3;
        end else begin
          acc_r <= hsum;
        end
      end
      S_NCHK: begin
        dmag_r <= T_TWO;
        if (acc_r == '0) st_r <= cuir_pkg::ST_ZERO_DER;
      end
      S_NDIV: if (div_done) dmag_r <= div_q;
      S_NUPD: begin
        t_r     <= ntc;
        tries_r <= tries_r + TRW'(1);
        step_r  <= STEP_FB;
        acc_r   <= XW'(a_r);
        if (CW'(diff) <= CW'(eps_r)) st_r <= cuir_pkg::ST_CONVERGED;
      end
      S_QSQ: begin
        oidx_r <= 1'b0;
        prod_r <= mul_a * mul_b;
      end
      S_QBD: begin
        m_r    <= KW'(prod_r >>> 2);
        prod_r <= mul_a * mul_b;
      end
      S_QM:    m_r <= m_r - KW'(prod_r);
      S_QSQRT: if (sq_done) r0_r <= sq_root;
      S_QRR:   prod_r <= mul_a * mul_b;
      S_QS: begin
        n_r   <= n_val;
        num_r <= n_val;
        den_r <= b2;
      end
      S_OFFER: begin
        if (!o_ok && !oidx_r) begin
          num_r  <= XW'(d_r) <<< 1;
          den_r  <= n_r;
          oidx_r <= 1'b1;
        end else if (!o_ok) begin
          t_r <= found_r ? best_r : '0;
        end
      end
      S_ODIV: begin
        if (div_done) begin
          found_r <= upd_found;
          best_r  <= upd_best;
          if (oidx_r) begin
            t_r <= upd_best;
          end else begin
            num_r  <= XW'(d_r) <<< 1;
            den_r  <= n_r;
            oidx_r <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r.root_t <= 17'(t_r);
      out_data_r.status <= st_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NMUL) |-> (t_r <= T_ONE)) else $error("t out of range");
  a_tries: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NMUL) |-> (tries_r < TRW'(MAX_TRIES))) else $error("tries overrun");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CLASS)) else $error("accept lost");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_NDIV || state_r == S_ODIV)) else $error("divide unwatched");

endmodule

`default_nettype wire

### bench/tb_cubic_unit_interval_root_top.sv
// ----------------------------------------------------------------------------
// tb_cubic_unit_interval_root_top: self-checking bench for the cubic root block
// A directed table and random coefficient items are checked against a local
// fixed-point predictor of the closed-form and Newton paths, over several
// epsilon settings and random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cubic_unit_interval_root_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTRY = 16;
  localparam int FB = 16;
  localparam longint ONE = 64'd1 << FB;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  cuir_pkg::in_t in_data;
  cuir_pkg::out_t out_data;
  logic [cuir_pkg::EPSW-1:0] cfg_data;

  cubic_unit_interval_root_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor copy of the tolerance
  logic [cuir_pkg::EPSW-1:0] eps_q;
  cuir_pkg::out_t roots_due[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // floor(x * t / ONE)
  function automatic longint scale_t(longint x, longint t);
    longint p;
    p = x * t;
    return p >>> FB;
  endfunction

  // floor(num * ONE / den), num < 2*den
  function automatic longint frac_q(longint num, longint den);
    longint q;
    q = 0;
    if (num >= den) begin
      q = 1;
      num -= den;
    end
    for (int i = 0; i < FB; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint int_sqrt(longint m);
    longint r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > m) b = b >> 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m -= r + b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // keep the smallest quantized candidate that lies in [0,1]
  function automatic void try_candidate(longint num, longint den, ref bit found,
                                        ref longint best);
    longint q;
    if (den == 0) return;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num < 0 || num > den) return;
    q = frac_q(num, den);
    if (!found || q < best) begin
      best = q;
      found = 1;
    end
  endfunction

  function automatic longint quad_root(longint b, longint c, longint d);
    bit found;
    longint best, uc, k, m, r0, s, n;
    found = 0;
    best = 0;
    if (d == 0) return 0;
    if (b == 0) begin
      try_candidate(-d, c, found, best);
      return found ? best : 0;
    end
    uc = (c < 0) ? -c : c;
    k = (uc * uc) >> 2;
    m = k - b * d;
    if (m < 0) return 0;
    r0 = int_sqrt(m);
    s = 2 * r0;
    if (r0 * r0 + r0 + ((uc & 1) ? 0 : 1) <= m) s += 1;
    n = (c >= 0) ? -(c + s) : (s - c);
    try_candidate(n, 2 * b, found, best);
    try_candidate(2 * d, n, found, best);
    return found ? best : 0;
  endfunction

  function automatic cuir_pkg::out_t predict_root(cuir_pkg::in_t x);
    cuir_pkg::out_t r;
    longint a, b, c, d, t, fv, dv, nu, de, dm, nt, diff;
    logic [1:0] st;
    a = x.coef_a;
    b = x.coef_b;
    c = x.coef_c;
    d = x.coef_d;
    st = cuir_pkg::ST_CLOSED;
    if (a == 0) t = quad_root(b, c, d);
    else if (d == 0) t = 0;
    else if (a + b + c + d == 0) t = ONE;
    else begin
      t = ONE >> 1;
      st = cuir_pkg::ST_EXHAUSTED;
      for (int i = 0; i < NTRY; i++) begin
        fv = scale_t(scale_t(scale_t(a, t) + b, t) + c, t) + d;
        dv = scale_t(scale_t(3 * a, t) + 2 * b, t) + c;
        if (dv == 0) begin
          st = cuir_pkg::ST_ZERO_DER;
          break;
        end
        nu = (fv < 0) ? -fv : fv;
        de = (dv < 0) ? -dv : dv;
        dm = (nu >= 2 * de) ? 2 * ONE : frac_q(nu, de);
        nt = ((fv < 0) != (dv < 0)) ? t + dm : t - dm;
        if (nt < 0) nt = 0;
        if (nt > ONE) nt = ONE;
        diff = (nt > t) ? nt - t : t - nt;
        t = nt;
        if (diff <= longint'(eps_q)) begin
          st = cuir_pkg::ST_CONVERGED;
          break;
        end
      end
    end
    r.root_t = t[16:0];
    r.status = st;
    return r;
  endfunction

  // result check and receiver stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (roots_due.size() == 0) begin
        $display("%0t: unexpected result root=%0d status=%0d", $realtime,
                 out_data.root_t, out_data.status);
        errors++;
      end else begin
        cuir_pkg::out_t e;
        e = roots_due.pop_front();
        if (e.root_t !== out_data.root_t) begin
          $display("%0t: root_t expected %0d actual %0d", $realtime, e.root_t,
                   out_data.root_t);
          errors++;
        end
        if (e.status !== out_data.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                   out_data.status);
          errors++;
        end
      end
    end
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // send one item; predicted at acceptance time
  task automatic send_coefs(cuir_pkg::in_t x, bit typed_in, cuir_pkg::out_t typed_exp);
    cuir_pkg::out_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_root(x);
    if (typed_in && p !== typed_exp) begin
      $display("%0t: table row expected %0d/%0d predictor %0d/%0d", $realtime,
               typed_exp.root_t, typed_exp.status, p.root_t, p.status);
      errors++;
    end
    roots_due.push_back(typed_in ? typed_exp : p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (roots_due.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_eps(logic [cuir_pkg::EPSW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    eps_q = v;
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(131072 * 8)) - 131072 * 4);
      2: return 32'($signed($urandom_range(65536 * 64)) - 65536 * 32);
      3: return 32'($signed($urandom_range(200)) - 100);
      4: return {32{1'b0}};
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // random item: mostly Newton cases, some closed-form
  task automatic random_batch(int n);
    cuir_pkg::in_t x;
    for (int i = 0; i < n; i++) begin
      x.coef_a = ($urandom_range(3) == 0) ? 32'd0 : rand_coef();
      x.coef_b = rand_coef();
      x.coef_c = rand_coef();
      x.coef_d = rand_coef();
      if ($urandom_range(19) == 0) x.coef_d = 0;
      if ($urandom_range(19) == 0)
        x.coef_d = -(x.coef_a + x.coef_b + x.coef_c);
      send_coefs(x, 0, '0);
    end
  endtask

  // directed rows: {a, b, c, d, typed, root, status}
  typedef struct {
    logic [31:0] a, b, c, d;
    bit typed;
    logic [16:0] root;
    logic [1:0] st;
  } row_t;

  row_t dir_rows[] = '{
    '{32'd0, 32'd0, 32'd0, 32'd0, 1, 17'd0, cuir_pkg::ST_CLOSED},
    '{32'd0, 32'd0, 32'd0, 32'h10000, 1, 17'd0, cuir_pkg::ST_CLOSED},
    '{32'd0, 32'd0, 32'h10000, 32'hffff8000, 1, 17'h8000, cuir_pkg::ST_CLOSED},
    '{32'd0, 32'd0, 32'h10000, 32'hffff0000, 1, 17'h10000, cuir_pkg::ST_CLOSED},
    '{32'd0, 32'h10000, 32'd0, 32'h10000, 1, 17'd0, cuir_pkg::ST_CLOSED},
    '{32'd0, 32'h10000, 32'hffff0000, 32'h4000, 0, 0, cuir_pkg::ST_CLOSED},
    '{32'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, cuir_pkg::ST_CLOSED},
    '{32'd0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, cuir_pkg::ST_CLOSED},
    '{32'h10000, 32'h10000, 32'h10000, 32'd0, 1, 17'd0, cuir_pkg::ST_CLOSED},
    '{32'h10000, 32'd0, 32'd0, 32'hffff0000, 1, 17'h10000, cuir_pkg::ST_CLOSED},
    '{32'h10000, 32'd0, 32'h10000, 32'hffff8000, 0, 0, cuir_pkg::ST_CLOSED},
    '{32'h10000, 32'hfffe8000, 32'h00008000, 32'h2000, 0, 0, cuir_pkg::ST_CLOSED},
    '{32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0, cuir_pkg::ST_CLOSED},
    '{32'h10000, 32'hfffe8000, 32'h0000c000, 32'h1, 0, 0, cuir_pkg::ST_CLOSED},
    '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0,
      cuir_pkg::ST_CLOSED},
    '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0,
      cuir_pkg::ST_CLOSED},
    '{32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff, 0, 0, cuir_pkg::ST_CLOSED},
    '{32'h1, 32'hffffffff, 32'h1, 32'h7fffffff, 0, 0, cuir_pkg::ST_CLOSED},
    '{32'hffffffff, 32'h00030000, 32'h7fffffff, 32'h80000000, 0, 0,
      cuir_pkg::ST_CLOSED},
    '{32'h5555aaaa, 32'haaaa5555, 32'h12345678, 32'hedcba987, 0, 0,
      cuir_pkg::ST_CLOSED}
  };

  initial begin
    cuir_pkg::in_t x;
    cuir_pkg::out_t e;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    eps_q = cuir_pkg::EPS_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset tolerance
    foreach (dir_rows[i]) begin
      x = {dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].d};
      e.root_t = dir_rows[i].root;
      e.status = dir_rows[i].st;
      send_coefs(x, dir_rows[i].typed, e);
    end
    drain_results();

    // random phases across tolerances and idling patterns
    send_idle_pct = 10;
    recv_idle_pct = 67;
    write_eps(16'd0);
    random_batch(230);
    drain_results();
    send_idle_pct = 67;
    recv_idle_pct = 10;
    write_eps(16'hffff);
    random_batch(230);
    drain_results();
    write_eps(16'd37);
    random_batch(220);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_eps(16'd1);
    random_batch(230);
    drain_results();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

### cubic_unit_interval_root_top.f
rtl/cuir_pkg.sv
rtl/cuir_div.sv
rtl/cuir_sqrt.sv
rtl/cubic_unit_interval_root_top.sv
bench/tb_cubic_unit_interval_root_top.sv
